FILE: src/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Constants, round table and mixing functions shared by the SHA-256 block
// ----------------------------------------------------------------------------
package sha256_pkg;

    // action codes of an input beat
    localparam logic [1:0] ACT_ABSORB     = 2'd0;
    localparam logic [1:0] ACT_ABSORB_FIN = 2'd1;
    localparam logic [1:0] ACT_FIN        = 2'd2;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        unique case (t)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

FILE: src/sha256_stream_hash_top.sv
// ----------------------------------------------------------------------------
// sha256_stream_hash_top
// Byte-serial SHA-256 hashing block with padding and digest readout
// ----------------------------------------------------------------------------
// Feed one message byte per input beat; a finishing beat pads the message and
// returns the digest as eight output beats, word 0 first, after which the
// block is ready for a new message. A byte that completes a 64-byte block
// starts a compression: 64 rounds through the single round unit, then the
// chaining add. A finish shifts the padding in one byte per cycle while no
// compression runs (up to 72 bytes, with one or two compressions), then
// holds the eight digest beats until they are taken. o_in_stall is high for
// all of that time.
// ----------------------------------------------------------------------------
module sha256_stream_hash_top
    import sha256_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_FINAL = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]   r_state, n_state;
    logic [5:0]   r_fill,  n_fill;
    logic [63:0]  r_total, n_total;
    logic [511:0] r_blk,   n_blk;
    logic [31:0]  r_v     [8];
    logic [31:0]  n_v     [8];
    logic [31:0]  r_chain [8];
    logic [31:0]  n_chain [8];
    logic [5:0]   r_rnd,   n_rnd;
    logic         r_fin,   n_fin;
    logic         r_mark,  n_mark;
    logic         r_len,   n_len;
    logic [63:0]  r_bits,  n_bits;
    logic [2:0]   r_idx,   n_idx;

    logic         in_acc;
    logic         out_acc;
    logic         shift_en;
    logic [7:0]   shift_byte;
    logic [31:0]  t1, t2, w_new, ch, maj;

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = (r_state == ST_OUT);
    assign o_digest_word = r_chain[r_idx];
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == 3'd7);

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = o_out_valid && !i_out_stall;

    // round unit and message schedule
    assign ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1    = r_v[7] + big_sigma1(r_v[4]) + ch + round_k(r_rnd) + r_blk[511:480];
    assign t2    = big_sigma0(r_v[0]) + maj;
    assign w_new = small_sigma1(r_blk[63:32]) + r_blk[223:192]
                 + small_sigma0(r_blk[479:448]) + r_blk[511:480];

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_total    = r_total;
        n_blk      = r_blk;
        n_v        = r_v;
        n_chain    = r_chain;
        n_rnd      = r_rnd;
        n_fin      = r_fin;
        n_mark     = r_mark;
        n_len      = r_len;
        n_bits     = r_bits;
        n_idx      = r_idx;
        shift_en   = 1'b0;
        shift_byte = i_data_byte;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (i_action)
                        ACT_ABSORB: begin
                            shift_en = 1'b1;
                            n_total  = r_total + 64'd1;
                        end
                        ACT_ABSORB_FIN: begin
                            shift_en = 1'b1;
                            n_total  = r_total + 64'd1;
                            n_fin    = 1'b1;
                            n_state  = ST_PAD;
                        end
                        ACT_FIN: begin
                            n_fin   = 1'b1;
                            n_state = ST_PAD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PAD: begin
                shift_en = 1'b1;
                if (!r_mark) begin
                    shift_byte = PAD_MARK;
                    n_mark     = 1'b1;
                    n_bits     = {r_total[60:0], 3'b000};
                end else if (r_len || r_fill == LEN_POS) begin
                    shift_byte = r_bits[63:56];
                    n_bits     = {r_bits[55:0], 8'h00};
                    n_len      = 1'b1;
                end else begin
                    shift_byte = 8'h00;
                end
            end
            ST_ROUND: begin
                n_v[7] = r_v[6];
                n_v[6] = r_v[5];
                n_v[5] = r_v[4];
                n_v[4] = r_v[3] + t1;
                n_v[3] = r_v[2];
                n_v[2] = r_v[1];
                n_v[1] = r_v[0];
                n_v[0] = t1 + t2;
                n_blk  = {r_blk[479:0], w_new};
                n_rnd  = r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                for (int i = 0; i < 8; i++) begin
                    n_chain[i] = r_chain[i] + r_v[i];
                end
                if (!r_fin) begin
                    n_state = ST_IDLE;
                end else if (r_len) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_PAD;
                end
            end
            ST_OUT: begin
                if (out_acc) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        n_chain = H_INIT;
                        n_total = 64'd0;
                        n_fin   = 1'b0;
                        n_mark  = 1'b0;
                        n_len   = 1'b0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // full block starts a compression
        if (shift_en) begin
            n_blk  = {r_blk[503:0], shift_byte};
            n_fill = r_fill + 6'd1;
            if (r_fill == 6'd63) begin
                n_state = ST_ROUND;
                n_v     = r_chain;
                n_rnd   = 6'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= 6'd0;
            r_total <= 64'd0;
            r_chain <= H_INIT;
            r_rnd   <= 6'd0;
            r_fin   <= 1'b0;
            r_mark  <= 1'b0;
            r_len   <= 1'b0;
            r_idx   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_total <= n_total;
            r_chain <= n_chain;
            r_rnd   <= n_rnd;
            r_fin   <= n_fin;
            r_mark  <= n_mark;
            r_len   <= n_len;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk  <= n_blk;
        r_v    <= n_v;
        r_bits <= n_bits;
    end

endmodule

FILE: src/sha256_checker.sv
// ----------------------------------------------------------------------------
// sha256_checker
// Port-level checks on the digest readout of the SHA-256 block
// ----------------------------------------------------------------------------
module sha256_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);

    // no new input while digest beats are pending
    a_busy_on_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken during digest readout");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_digest_word) && $stable(o_word_index))
        else $error("stalled digest beat changed");

    a_next_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last_word |=>
            o_out_valid && o_word_index == $past(o_word_index) + 3'd1)
        else $error("digest words out of order");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_word |-> o_word_index == 3'd7)
        else $error("last word flag on wrong word");

    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_word && !i_out_stall |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after digest");

endmodule

bind sha256_stream_hash_top sha256_checker u_sha256_checker (.*);
